@@ hdl/i2cm_pkg.sv @@
// Package: command codes, sequence constants and engine state type.
package i2cm_pkg;

  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_STOP      = 3'd1;
  localparam logic [2:0] CMD_SEND_ACK  = 3'd2;
  localparam logic [2:0] CMD_RECV_ACK  = 3'd3;
  localparam logic [2:0] CMD_SEND_BYTE = 3'd4;
  localparam logic [2:0] CMD_RECV_BYTE = 3'd5;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
  localparam logic [5:0] SEND_LAST = 6'(3 * BITS_PER_BYTE - 1);
  localparam logic [5:0] RECV_LAST = 6'(2 * BITS_PER_BYTE);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [2:0] cmd;
    logic       busy;
    logic [5:0] step;
    logic [1:0] phase;
    logic [7:0] shift;
    logic [7:0] poll;
    logic       ack;
    logic [7:0] rx;
  } i2cm_state_t;

  localparam i2cm_state_t STATE_RESET = '{
    scl:   1'b1,
    sda:   1'b1,
    cmd:   CMD_START,
    busy:  1'b0,
    step:  6'd0,
    phase: PH_DATA,
    shift: 8'd0,
    poll:  8'd0,
    ack:   1'b1,
    rx:    8'd0
  };

endpackage

@@ hdl/i2cm_if.sv @@
// Valid/ready channel interfaces for tick beats and result beats.
interface i2cm_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] func;
  logic [7:0] tx_byte;
  logic       ack_bit;
  logic       sda_in;

  modport source (output valid, cmd_valid, func, tx_byte, ack_bit, sda_in, input ready);
  modport sink (input valid, cmd_valid, func, tx_byte, ack_bit, sda_in, output ready);
endinterface

interface i2cm_result_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_received,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_received,
                output ready);
endinterface

@@ hdl/i2c_master_bit_engine.sv @@
// A tick beat is held in the tick input register until the result register can take its result beat.
// Throughput: one tick per cycle while the result channel is ready; set by the engine state update loop.
// Path: tick input register, one pass of pin-action logic, result register.
// Reset (rst, synchronous): SCL and SDA released, engine idle, ack level 1, rx byte 0,
// ack_timeout 200; both channel registers empty.
module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  i2cm_tick_if.sink          tick,
  i2cm_result_if.source      result
);

  logic        in_valid;
  logic        in_cmd_valid;
  logic [2:0]  in_func;
  logic [7:0]  in_tx_byte;
  logic        in_ack_bit;
  logic        in_sda_in;
  logic        res_valid;
  logic        res_done;
  logic [7:0]  ack_timeout;
  logic        advance;
  i2cm_state_t st;
  i2cm_state_t st_next;
  i2cm_state_t res;
  logic        done_next;

  assign advance    = in_valid && (!res_valid || result.ready);
  assign tick.ready = !in_valid || advance;

  i2cm_step u_step (
    .cur         (st),
    .cmd_valid   (in_cmd_valid),
    .func        (in_func),
    .tx_byte     (in_tx_byte),
    .ack_bit     (in_ack_bit),
    .sda_in      (in_sda_in),
    .ack_timeout (ack_timeout),
    .nxt         (st_next),
    .done        (done_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      ack_timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_cmd_valid <= tick.cmd_valid;
      in_func      <= tick.func;
      in_tx_byte   <= tick.tx_byte;
      in_ack_bit   <= tick.ack_bit;
      in_sda_in    <= tick.sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        st <= st_next;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res      <= st_next;
      res_done <= done_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.scl_out      = res.scl;
  assign result.sda_out      = res.sda;
  assign result.busy_res     = res.busy;
  assign result.done_res     = res_done;
  assign result.rx_byte      = res.rx;
  assign result.ack_received = res.ack;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_done) |-> !res.busy)
    else $error("done beat shows engine still busy");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick.ready)
    else $error("tick not accepted while result register empty");

  a_state_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> $stable(st))
    else $error("engine state moved while result stalled");

  a_send_step_range: assert property (@(posedge clk) disable iff (rst)
    (st.busy && st.cmd == CMD_SEND_BYTE) |-> (st.step <= SEND_LAST))
    else $error("send byte step beyond last bit");

  a_ack_step_range: assert property (@(posedge clk) disable iff (rst)
    (st.busy && st.cmd == CMD_RECV_ACK) |-> (st.step <= 6'd3))
    else $error("receive ack step out of range");
`endif

endmodule

@@ hdl/i2cm_step.sv @@
// Per-tick state update: command launch and one pin action.
module i2cm_step
  import i2cm_pkg::*;
(
  input  i2cm_state_t cur,
  input  logic        cmd_valid,
  input  logic [2:0]  func,
  input  logic [7:0]  tx_byte,
  input  logic        ack_bit,
  input  logic        sda_in,
  input  logic [7:0]  ack_timeout,
  output i2cm_state_t nxt,
  output logic        done
);

  always_comb begin
    i2cm_state_t st;
    logic        fin;
    logic        hold_step;
    logic [7:0]  poll_inc;
    logic [7:0]  shift_in;

    st = cur;
    fin = 1'b0;
    hold_step = 1'b0;
    poll_inc = cur.poll + 8'd1;
    shift_in = {cur.shift[6:0], sda_in};

    if (!cur.busy && cmd_valid && func <= CMD_RECV_BYTE) begin
      st.busy = 1'b1;
      st.cmd = func;
      st.step = 6'd0;
      st.phase = PH_DATA;
      if (func == CMD_SEND_BYTE) begin
        st.shift = tx_byte;
      end else if (func == CMD_RECV_BYTE) begin
        st.shift = 8'd0;
      end
      poll_inc = st.poll + 8'd1;
      shift_in = {st.shift[6:0], sda_in};
    end

    if (st.busy) begin
      case (st.cmd)
        CMD_START: begin
          if (st.step == 6'd0) st.sda = 1'b1;
          else if (st.step == 6'd1) st.scl = 1'b1;
          else if (st.step == 6'd2) st.sda = 1'b0;
          else begin
            st.scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_STOP: begin
          if (st.step == 6'd0) st.scl = 1'b0;
          else if (st.step == 6'd1) st.sda = 1'b0;
          else if (st.step == 6'd2) st.scl = 1'b1;
          else begin
            st.sda = 1'b1;
            fin = 1'b1;
          end
        end
        CMD_SEND_ACK: begin
          if (st.step == 6'd0) st.sda = ack_bit;
          else if (st.step == 6'd1) st.scl = 1'b1;
          else begin
            st.scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_RECV_ACK: begin
          if (st.step == 6'd0) begin
            st.sda = 1'b1;
          end else if (st.step == 6'd1) begin
            st.scl = 1'b1;
            st.poll = 8'd0;
            if (ack_timeout == 8'd0) begin
              st.ack = 1'b1;
              st.step = 6'd3;
              hold_step = 1'b1;
            end
          end else if (st.step == 6'd2) begin
            hold_step = 1'b1;
            if (!sda_in) begin
              st.ack = 1'b0;
              st.step = 6'd3;
            end else begin
              st.poll = poll_inc;
              if (poll_inc >= ack_timeout) begin
                st.ack = 1'b1;
                st.step = 6'd3;
              end
            end
          end else begin
            st.scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_SEND_BYTE: begin
          case (st.phase)
            PH_DATA: begin
              st.sda = st.shift[7];
              st.phase = PH_HIGH;
            end
            PH_HIGH: begin
              st.scl = 1'b1;
              st.phase = PH_LOW;
            end
            default: begin
              st.scl = 1'b0;
              st.shift = {st.shift[6:0], 1'b0};
              st.phase = PH_DATA;
              if (st.step >= SEND_LAST) fin = 1'b1;
            end
          endcase
        end
        default: begin
          if (st.step == 6'd0) begin
            st.sda = 1'b1;
          end else if (st.step[0]) begin
            st.scl = 1'b1;
          end else begin
            st.shift = shift_in;
            st.scl = 1'b0;
            if (st.step >= RECV_LAST) begin
              st.rx = shift_in;
              fin = 1'b1;
            end
          end
        end
      endcase

      if (fin) begin
        st.busy = 1'b0;
        st.step = 6'd0;
      end else if (!hold_step) begin
        st.step = st.step + 6'd1;
      end
    end

    nxt = st;
    done = fin;
  end

endmodule

@@ verif/i2c_master_bit_engine_test.sv @@
// Testbench for the I2C master bit engine: directed and random ticks scored by a line model.
module i2c_master_bit_engine_test;
  import i2cm_pkg::*;

  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
  } line_t;

  typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_COMB} stall_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  i2cm_tick_if tick_ch();
  i2cm_result_if result_ch();

  i2c_master_bit_engine DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .tick(tick_ch),
    .result(result_ch)
  );

  always #6 clk = ~clk;

  // line model state
  logic       eng_scl = 1'b1;
  logic       eng_sda = 1'b1;
  logic [2:0] eng_cmd = CMD_START;
  logic       eng_busy = 1'b0;
  logic [5:0] eng_step = '0;
  logic [7:0] eng_shift = '0;
  logic [7:0] eng_poll = '0;
  logic       eng_ack = 1'b1;
  logic [7:0] eng_rx = '0;
  logic [7:0] ack_limit = ACK_TIMEOUT_RESET;

  line_t line_q[$];
  int    err_count = 0;
  int    sent_count = 0;
  int    burst_left = 0;
  bit    steady = 1'b0;
  int    hold_req = 0;
  int    hold_left = 0;
  int    mode_left = 0;
  int    rx_cyc = 0;
  stall_t rx_mode = RX_FLOW;
  line_t got, want;

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void predict_pins(input tick_t t);
    logic  fin;
    logic  hold;
    line_t r;
    fin = 1'b0;
    hold = 1'b0;
    if (!eng_busy && t.cmd_valid && t.func <= CMD_RECV_BYTE) begin
      eng_busy = 1'b1;
      eng_cmd = t.func;
      eng_step = '0;
      if (t.func == CMD_SEND_BYTE) eng_shift = t.tx_byte;
      else if (t.func == CMD_RECV_BYTE) eng_shift = '0;
    end
    if (eng_busy) begin
      case (eng_cmd)
        CMD_START: begin
          if (eng_step == 0) eng_sda = 1'b1;
          else if (eng_step == 1) eng_scl = 1'b1;
          else if (eng_step == 2) eng_sda = 1'b0;
          else begin
            eng_scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_STOP: begin
          if (eng_step == 0) eng_scl = 1'b0;
          else if (eng_step == 1) eng_sda = 1'b0;
          else if (eng_step == 2) eng_scl = 1'b1;
          else begin
            eng_sda = 1'b1;
            fin = 1'b1;
          end
        end
        CMD_SEND_ACK: begin
          if (eng_step == 0) eng_sda = t.ack_bit;
          else if (eng_step == 1) eng_scl = 1'b1;
          else begin
            eng_scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_RECV_ACK: begin
          if (eng_step == 0) eng_sda = 1'b1;
          else if (eng_step == 1) begin
            eng_scl = 1'b1;
            eng_poll = '0;
            if (ack_limit == 0) begin
              eng_ack = 1'b1;
              eng_step = 6'd3;
              hold = 1'b1;
            end
          end else if (eng_step == 2) begin
            hold = 1'b1;
            if (!t.sda_in) begin
              eng_ack = 1'b0;
              eng_step = 6'd3;
            end else begin
              eng_poll = eng_poll + 8'd1;
              if (eng_poll >= ack_limit) begin
                eng_ack = 1'b1;
                eng_step = 6'd3;
              end
            end
          end else begin
            eng_scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_SEND_BYTE: begin
          case (2'(eng_step % 3))
            PH_DATA: eng_sda = eng_shift[7];
            PH_HIGH: eng_scl = 1'b1;
            default: begin
              eng_scl = 1'b0;
              eng_shift = {eng_shift[6:0], 1'b0};
              if (eng_step >= SEND_LAST) fin = 1'b1;
            end
          endcase
        end
        default: begin
          if (eng_step == 0) eng_sda = 1'b1;
          else if (eng_step[0]) eng_scl = 1'b1;
          else begin
            eng_shift = {eng_shift[6:0], t.sda_in};
            eng_scl = 1'b0;
            if (eng_step >= RECV_LAST) begin
              eng_rx = eng_shift;
              fin = 1'b1;
            end
          end
        end
      endcase
      if (fin) begin
        eng_busy = 1'b0;
        eng_step = '0;
      end else if (!hold) begin
        eng_step = eng_step + 6'd1;
      end
    end
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = eng_busy;
    r.done = fin;
    r.rx = eng_rx;
    r.ack = eng_ack;
    line_q.push_back(r);
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.cmd_valid <= t.cmd_valid;
    tick_ch.func <= t.func;
    tick_ch.tx_byte <= t.tx_byte;
    tick_ch.ack_bit <= t.ack_bit;
    tick_ch.sda_in <= t.sda_in;
    do @(posedge clk); while (!tick_ch.ready);
    predict_pins(t);
    sent_count++;
  endtask

  function automatic tick_t filler(input int low_pct);
    tick_t f;
    f.cmd_valid = 1'($urandom_range(0, 1));
    f.func = 3'($urandom_range(0, 7));
    f.tx_byte = 8'($urandom);
    f.ack_bit = 1'($urandom_range(0, 1));
    f.sda_in = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
    return f;
  endfunction

  // command beat, then random beats (commands among them are ignored) until done
  task automatic run_command(input logic [2:0] func, input logic [7:0] tx, input logic ackb,
                             input int low_pct);
    tick_t c;
    c = filler(low_pct);
    c.cmd_valid = 1'b1;
    c.func = func;
    c.tx_byte = tx;
    c.ack_bit = ackb;
    send_tick(c);
    while (eng_busy) send_tick(filler(low_pct));
  endtask

  task automatic drain_lines();
    tick_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (line_q.size() != 0);
  endtask

  task automatic set_timeout(input logic [7:0] v);
    drain_lines();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ack_limit = v;
  endtask

  task automatic test_idle_after_reset();
    tick_t t;
    t = filler(0);
    t.cmd_valid = 1'b0;
    send_tick(t);
    t.sda_in = 1'b0;
    send_tick(t);
  endtask

  task automatic test_commands();
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_SEND_BYTE, 8'hFF, 1'b0, 50);
    run_command(CMD_SEND_BYTE, 8'h00, 1'b1, 50);
    run_command(CMD_SEND_BYTE, 8'hA5, 1'b0, 50);
    run_command(CMD_RECV_ACK, 8'h00, 1'b0, 100);
    run_command(CMD_SEND_ACK, 8'h00, 1'b0, 50);
    run_command(CMD_SEND_ACK, 8'hFF, 1'b1, 50);
    run_command(CMD_RECV_BYTE, 8'h00, 1'b0, 0);
    run_command(CMD_RECV_BYTE, 8'hFF, 1'b1, 100);
    run_command(CMD_RECV_BYTE, 8'h5A, 1'b1, 50);
    run_command(CMD_STOP, 8'h00, 1'b0, 50);
  endtask

  task automatic test_reserved_funcs();
    tick_t t;
    t = filler(50);
    t.cmd_valid = 1'b1;
    t.func = FUNC_RSVD6;
    send_tick(t);
    t.func = FUNC_RSVD7;
    t.sda_in = ~t.sda_in;
    send_tick(t);
  endtask

  task automatic test_ack_timeout();
    set_timeout(8'd1);
    run_command(CMD_RECV_ACK, 8'h00, 1'b0, 0);
    set_timeout(8'd0);
    run_command(CMD_RECV_ACK, 8'h00, 1'b0, 0);
    set_timeout(8'd255);
    run_command(CMD_RECV_ACK, 8'h00, 1'b0, 0);
    // drop the limit below the poll count mid-wait
    set_timeout(ACK_TIMEOUT_RESET);
    run_command(CMD_START, 8'h00, 1'b0, 50);
    send_tick('{cmd_valid: 1'b1, func: CMD_RECV_ACK, tx_byte: 8'h00, ack_bit: 1'b0,
                sda_in: 1'b1});
    repeat (12) send_tick(filler(0));
    set_timeout(8'd5);
    while (eng_busy) send_tick(filler(0));
  endtask

  task automatic test_backpressure();
    drain_lines();
    hold_req = 400;
    steady = 1'b1;
    run_command(CMD_SEND_BYTE, 8'($urandom), 1'b0, 50);
    run_command(CMD_RECV_BYTE, 8'h00, 1'b0, 50);
    run_command(CMD_SEND_BYTE, 8'($urandom), 1'b1, 50);
    run_command(CMD_RECV_BYTE, 8'h00, 1'b0, 50);
    steady = 1'b0;
    drain_lines();
  endtask

  task automatic test_random(input logic [7:0] limit, input int n);
    int    stop_at;
    int    low_pct;
    tick_t t;
    set_timeout(limit);
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 3))
          0: low_pct = 0;
          1: low_pct = 5;
          2: low_pct = 40;
          default: low_pct = 100;
        endcase
        run_command(3'($urandom_range(0, 5)), 8'($urandom), 1'($urandom_range(0, 1)),
                    low_pct);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          t = filler(50);
          if (t.func <= CMD_RECV_BYTE) t.cmd_valid = 1'b0;
          send_tick(t);
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = stall_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_FLOW:  result_ch.ready <= 1'b1;
        RX_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: result_ch.ready <= ($urandom_range(0, 9) < 3);
        default:  result_ch.ready <= (rx_cyc % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{scl: result_ch.scl_out, sda: result_ch.sda_out, busy: result_ch.busy_res,
              done: result_ch.done_res, rx: result_ch.rx_byte, ack: result_ch.ack_received};
      if (line_q.size() == 0) begin
        note_error($sformatf("unexpected beat scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                             got.scl, got.sda, got.busy, got.done, got.rx, got.ack));
      end else begin
        want = line_q.pop_front();
        if (got !== want)
          note_error($sformatf({"beat mismatch exp scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                " got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b"},
                               want.scl, want.sda, want.busy, want.done, want.rx, want.ack,
                               got.scl, got.sda, got.busy, got.done, got.rx, got.ack));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("i2c_master_bit_engine_test: done, errors");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.cmd_valid <= 1'b0;
    tick_ch.func <= CMD_START;
    tick_ch.tx_byte <= '0;
    tick_ch.ack_bit <= 1'b0;
    tick_ch.sda_in <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_after_reset();
    test_commands();
    test_reserved_funcs();
    test_ack_timeout();
    test_backpressure();
    test_random(ACK_TIMEOUT_RESET, 60);
    test_random(8'd1, 60);
    test_random(8'd3, 60);
    test_random(8'd255, 60);
    test_random(8'd37, 60);

    drain_lines();
    repeat (10) @(posedge clk);
    if (line_q.size() != 0) note_error("expected beats left over");
    if (err_count == 0) begin
      $display("i2c_master_bit_engine_test: done, clean");
    end else begin
      $display("i2c_master_bit_engine_test: done, errors");
    end
    $finish;
  end

endmodule
